// ===== sv/vnorm_pkg.sv =====
// Package for the vector normalisation block.
// Holds the shared constants; used by the channel interfaces and the top level.
package vnorm_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int MAX_DIMS_DEF        = 4;
  localparam int DIMS_W              = 3;
  localparam int UNIT_W              = 16;
  localparam int LANES               = 4;
  localparam int MIN_DIMS            = 2;
  localparam int FRAC_BITS           = 32;
  localparam int QUOT_W              = FRAC_BITS + 1;
  localparam int ROOT_W              = (QUOT_W + 1) / 2;

endpackage

// ===== sv/vnorm_in_if.sv =====
// Input channel of the vector normalisation block: valid/ready and one vector item.
// Depends on vnorm_pkg.
interface vnorm_in_if import vnorm_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic        [DIMS_W-1:0]          dims;
  logic signed [COMPONENT_WIDTH-1:0] comp_x;
  logic signed [COMPONENT_WIDTH-1:0] comp_y;
  logic signed [COMPONENT_WIDTH-1:0] comp_z;
  logic signed [COMPONENT_WIDTH-1:0] comp_w;

  modport source (output valid, dims, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, dims, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

// ===== sv/vnorm_out_if.sv =====
// Result channel of the vector normalisation block: valid/ready and one unit vector item.
// Depends on vnorm_pkg.
interface vnorm_out_if import vnorm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [UNIT_W-1:0] unit_x;
  logic signed [UNIT_W-1:0] unit_y;
  logic signed [UNIT_W-1:0] unit_z;
  logic signed [UNIT_W-1:0] unit_w;
  logic                     zero_length;

  modport source (output valid, unit_x, unit_y, unit_z, unit_w, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, zero_length, output ready);
endinterface

// ===== sv/vector_normalize.sv =====
// Vector normalisation top level: a fully pipelined unit-vector datapath.
// Depends on vnorm_pkg, vnorm_in_if and vnorm_out_if.
//
// Each item's vector is scaled to unit length and returned in signed Q1.15. The
// datapath is a pipeline of 54 register stages: magnitude, squaring, summation,
// 33 stages of a one-bit-per-stage restoring divider, 17 stages of a
// two-bits-per-stage square root and a rounding stage. One item is accepted every
// cycle unless the pipeline holds. The whole pipeline holds while the output
// register holds a result that has not been taken.
module vector_normalize import vnorm_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int MAX_DIMS        = MAX_DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vnorm_in_if.sink    in_ch,
  vnorm_out_if.source out_ch
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int SQW  = 2 * W;
  localparam int SUMW = 2 * W + 2;
  localparam int QB   = QUOT_W;
  localparam int RB   = ROOT_W;
  localparam int VW   = 2 * RB;
  localparam int RMW  = RB + 2;

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: clamp dimension, take magnitudes, remove a common factor of two.
  logic [W-1:0]       comp_in [LANES];
  logic [W-1:0]       mag1_nxt [LANES];
  logic [LANES-1:0]   neg1_nxt;
  logic [W-1:0]       mag1_r [LANES];
  logic [LANES-1:0]   neg1_r;
  logic               v1_r;

  assign comp_in[0] = in_ch.comp_x;
  assign comp_in[1] = in_ch.comp_y;
  assign comp_in[2] = in_ch.comp_z;
  assign comp_in[3] = in_ch.comp_w;

  always_comb begin
    logic [DIMS_W-1:0] n;
    logic              all_even;
    n = in_ch.dims;
    if (n < DIMS_W'(MIN_DIMS)) begin
      n = DIMS_W'(MIN_DIMS);
    end
    if (n > DIMS_W'(MAX_DIMS)) begin
      n = DIMS_W'(MAX_DIMS);
    end
    all_even = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (DIMS_W'(i) < n) begin
        neg1_nxt[i] = comp_in[i][W-1];
        mag1_nxt[i] = comp_in[i][W-1] ? (~comp_in[i] + W'(1)) : comp_in[i];
      end else begin
        neg1_nxt[i] = 1'b0;
        mag1_nxt[i] = '0;
      end
      if (mag1_nxt[i][0]) begin
        all_even = 1'b0;
      end
    end
    if (all_even) begin
      for (int i = 0; i < LANES; i++) begin
        mag1_nxt[i] = mag1_nxt[i] >> 1;
      end
    end
  end

  // Stages 2 and 3: squares, then their sum.
  logic [SQW-1:0]     sq2_r [LANES];
  logic [LANES-1:0]   neg2_r;
  logic               v2_r;
  logic [SQW-1:0]     sq3_r [LANES];
  logic [SUMW-1:0]    sum3_r;
  logic [LANES-1:0]   neg3_r;
  logic               zero3_r;
  logic               v3_r;
  logic [SUMW-1:0]    sum3_nxt;

  always_comb begin
    sum3_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      sum3_nxt = sum3_nxt + SUMW'(sq2_r[i]);
    end
  end

  // Division stages: one quotient bit of sq * 2^32 / sum per stage.
  logic [QB-1:0]      dq_r   [QB][LANES];
  logic [SUMW-1:0]    dr_r   [QB][LANES];
  logic [QB-1:0]      dq_nxt [QB][LANES];
  logic [SUMW-1:0]    dr_nxt [QB][LANES];
  logic [SUMW-1:0]    dsum_r [QB];
  logic [LANES-1:0]   dneg_r [QB];
  logic [QB-1:0]      dzero_r;
  logic [QB-1:0]      dv_r;

  always_comb begin
    logic [SUMW:0] r2;
    logic          ge;
    for (int d = 0; d < QB; d++) begin
      for (int i = 0; i < LANES; i++) begin
        if (d == 0) begin
          r2 = (SUMW + 1)'(sq3_r[i]);
          ge = r2 >= {1'b0, sum3_r};
          dq_nxt[d][i] = QB'(ge);
          dr_nxt[d][i] = SUMW'(ge ? (r2 - {1'b0, sum3_r}) : r2);
        end else begin
          r2 = {dr_r[d-1][i], 1'b0};
          ge = r2 >= {1'b0, dsum_r[d-1]};
          dq_nxt[d][i] = {dq_r[d-1][i][QB-2:0], ge};
          dr_nxt[d][i] = SUMW'(ge ? (r2 - {1'b0, dsum_r[d-1]}) : r2);
        end
      end
    end
  end

  // Square root stages: one root bit per stage.
  logic [VW-1:0]      sval_r   [RB][LANES];
  logic [RMW-1:0]     srem_r   [RB][LANES];
  logic [RB-1:0]      sroot_r  [RB][LANES];
  logic [VW-1:0]      sval_nxt [RB][LANES];
  logic [RMW-1:0]     srem_nxt [RB][LANES];
  logic [RB-1:0]      sroot_nxt[RB][LANES];
  logic [LANES-1:0]   sneg_r [RB];
  logic [RB-1:0]      szero_r;
  logic [RB-1:0]      sv_r;

  always_comb begin
    logic [VW-1:0]  val;
    logic [RMW-1:0] rem;
    logic [RB-1:0]  root;
    logic [RMW+1:0] pre;
    logic [RMW+1:0] trial;
    logic           ge;
    for (int s = 0; s < RB; s++) begin
      for (int i = 0; i < LANES; i++) begin
        if (s == 0) begin
          val  = VW'(dq_r[QB-1][i]);
          rem  = '0;
          root = '0;
        end else begin
          val  = sval_r[s-1][i];
          rem  = srem_r[s-1][i];
          root = sroot_r[s-1][i];
        end
        pre   = {rem, val[VW-1:VW-2]};
        trial = (RMW + 2)'({root, 2'b01});
        ge    = pre >= trial;
        srem_nxt[s][i]  = RMW'(ge ? (pre - trial) : pre);
        sroot_nxt[s][i] = {root[RB-2:0], ge};
        sval_nxt[s][i]  = {val[VW-3:0], 2'b00};
      end
    end
  end

  // Output stage: round half up, saturate, apply sign.
  logic signed [UNIT_W-1:0] unit_nxt [LANES];
  logic signed [UNIT_W-1:0] unit_r   [LANES];
  logic                     zero_r;
  logic                     ov_r;

  always_comb begin
    logic [RB:0]       t1;
    logic [RB-1:0]     rr;
    logic [UNIT_W:0]   neg_full;
    for (int i = 0; i < LANES; i++) begin
      t1 = (RB + 1)'(sroot_r[RB-1][i]) + (RB + 1)'(1);
      rr = RB'(t1 >> 1);
      neg_full = '0;
      if (szero_r[RB-1]) begin
        unit_nxt[i] = '0;
      end else if (sneg_r[RB-1][i]) begin
        if (rr > RB'(32768)) begin
          rr = RB'(32768);
        end
        neg_full    = (UNIT_W + 1)'(1 << UNIT_W) - (UNIT_W + 1)'(rr);
        unit_nxt[i] = UNIT_W'(neg_full);
      end else begin
        if (rr > RB'(32767)) begin
          rr = RB'(32767);
        end
        unit_nxt[i] = UNIT_W'(rr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      dv_r    <= '0;
      sv_r    <= '0;
      ov_r    <= 1'b0;
    end else if (en) begin
      v1_r    <= in_ch.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      dv_r    <= {dv_r[QB-2:0], v3_r};
      sv_r    <= {sv_r[RB-2:0], dv_r[QB-1]};
      ov_r    <= sv_r[RB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= neg1_nxt;
      neg2_r  <= neg1_r;
      neg3_r  <= neg2_r;
      sum3_r  <= sum3_nxt;
      zero3_r <= (sum3_nxt == '0);
      for (int i = 0; i < LANES; i++) begin
        mag1_r[i] <= mag1_nxt[i];
        sq2_r[i]  <= SQW'(mag1_r[i]) * SQW'(mag1_r[i]);
        sq3_r[i]  <= sq2_r[i];
      end
      for (int d = 0; d < QB; d++) begin
        dsum_r[d]  <= (d == 0) ? sum3_r  : dsum_r[d-1];
        dneg_r[d]  <= (d == 0) ? neg3_r  : dneg_r[d-1];
        dzero_r[d] <= (d == 0) ? zero3_r : dzero_r[d-1];
        for (int i = 0; i < LANES; i++) begin
          dq_r[d][i] <= dq_nxt[d][i];
          dr_r[d][i] <= dr_nxt[d][i];
        end
      end
      for (int s = 0; s < RB; s++) begin
        sneg_r[s]  <= (s == 0) ? dneg_r[QB-1]  : sneg_r[s-1];
        szero_r[s] <= (s == 0) ? dzero_r[QB-1] : szero_r[s-1];
        for (int i = 0; i < LANES; i++) begin
          sval_r[s][i]  <= sval_nxt[s][i];
          srem_r[s][i]  <= srem_nxt[s][i];
          sroot_r[s][i] <= sroot_nxt[s][i];
        end
      end
      zero_r <= szero_r[RB-1];
      for (int i = 0; i < LANES; i++) begin
        unit_r[i] <= unit_nxt[i];
      end
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.unit_x      = unit_r[0];
  assign out_ch.unit_y      = unit_r[1];
  assign out_ch.unit_z      = unit_r[2];
  assign out_ch.unit_w      = unit_r[3];
  assign out_ch.zero_length = zero_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for vector_normalize: directed, random and back-pressure items.
// Depends on vnorm_pkg, vnorm_in_if, vnorm_out_if and vector_normalize.
module tb_top;
  import vnorm_pkg::*;

  typedef struct {
    logic signed [UNIT_W-1:0] ux, uy, uz, uw;
    logic                     zl;
  } unit_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches = 0;
  bit   idle_on = 1'b0;
  int   hold_cycles = 0;
  unit_vec_t unit_queue[$];

  vnorm_in_if  in_ch ();
  vnorm_out_if out_ch ();

  vector_normalize dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.dims = '0;
    in_ch.comp_x = '0;
    in_ch.comp_y = '0;
    in_ch.comp_z = '0;
    in_ch.comp_w = '0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic unit_vec_t normalise(input logic [DIMS_W-1:0] dims,
                                          input logic signed [15:0] cx, cy, cz, cw);
    logic signed [15:0] comp[4];
    logic [63:0] mag[4];
    bit          neg[4];
    logic [63:0] sum, t, r;
    logic [95:0] quot;
    logic [15:0] lane[4];
    int          n;
    bit          all_even;
    unit_vec_t   res;
    comp = '{cx, cy, cz, cw};
    n = (dims < MIN_DIMS) ? MIN_DIMS : (dims > LANES) ? LANES : dims;
    all_even = 1'b1;
    sum = 0;
    for (int i = 0; i < LANES; i++) begin
      neg[i] = (i < n) && comp[i] < 0;
      mag[i] = (i >= n) ? 64'd0 : neg[i] ? 64'(-int'(comp[i])) : 64'(comp[i]);
      if (mag[i][0]) all_even = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (all_even) mag[i] = mag[i] >> 1;
      sum += mag[i] * mag[i];
    end
    for (int i = 0; i < LANES; i++) begin
      lane[i] = '0;
      if (sum != 0 && i < n && mag[i] != 0) begin
        quot = ({32'd0, mag[i] * mag[i]} << 32) / {32'd0, sum};
        t = int_sqrt(quot[63:0]);
        r = (t + 1) >> 1;
        if (neg[i]) begin
          if (r > 32768) r = 32768;
          lane[i] = 16'(17'h10000 - r);
        end else begin
          if (r > 32767) r = 32767;
          lane[i] = r[15:0];
        end
      end
    end
    res.ux = lane[0];
    res.uy = lane[1];
    res.uz = lane[2];
    res.uw = lane[3];
    res.zl = (sum == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
  endtask

  // Sends one item; valid stays high into the next item unless an idle burst follows.
  task automatic send_vector(input logic [DIMS_W-1:0] dims,
                             input logic signed [15:0] cx, cy, cz, cw);
    bit done;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.dims = dims;
    in_ch.comp_x = cx;
    in_ch.comp_y = cy;
    in_ch.comp_z = cz;
    in_ch.comp_w = cw;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (in_ch.ready) begin
        unit_queue.push_back(normalise(dims, cx, cy, cz, cw));
        done = 1'b1;
      end
    end
    @(negedge clk);
  endtask

  // Receiver side: long hold when asked, otherwise random stall bursts while idle_on is set.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk) begin
    unit_vec_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (unit_queue.size() == 0) begin
        report_mismatch("result with no expectation");
      end else begin
        exp_v = unit_queue.pop_front();
        if (out_ch.unit_x !== exp_v.ux)
          report_mismatch($sformatf("unit_x %0d, expected %0d", out_ch.unit_x, exp_v.ux));
        if (out_ch.unit_y !== exp_v.uy)
          report_mismatch($sformatf("unit_y %0d, expected %0d", out_ch.unit_y, exp_v.uy));
        if (out_ch.unit_z !== exp_v.uz)
          report_mismatch($sformatf("unit_z %0d, expected %0d", out_ch.unit_z, exp_v.uz));
        if (out_ch.unit_w !== exp_v.uw)
          report_mismatch($sformatf("unit_w %0d, expected %0d", out_ch.unit_w, exp_v.uw));
        if (out_ch.zero_length !== exp_v.zl)
          report_mismatch($sformatf("zero_length %0b, expected %0b",
                                    out_ch.zero_length, exp_v.zl));
      end
    end
  end

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 15)) - 16'sd8;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($urandom) & 16'hfffe;
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [DIMS_W-1:0] dims;
    dims = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4));
    send_vector(dims, rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic test_directed();
    for (int d = 0; d < 8; d++) send_vector(3'(d), 16'sd3, -16'sd4, 16'sd12, 16'sd5);
    send_vector(3'd2, 16'sd0, 16'sd0, 16'sd7, 16'sd9);
    send_vector(3'd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_vector(3'd2, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
    send_vector(3'd2, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_vector(3'd3, 16'sd0, -16'sd1, 16'sd0, 16'sd0);
    send_vector(3'd4, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_vector(3'd4, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_vector(3'd2, 16'sd1, 16'sd1, 16'sd0, 16'sd0);
    send_vector(3'd3, 16'sd2, 16'sd4, -16'sd6, 16'sd0);
    send_vector(3'd4, 16'sh7fff, 16'sd1, -16'sd1, 16'sd1);
    send_vector(3'd3, -16'sd1, -16'sd1, -16'sd1, 16'sh7fff);
    send_vector(3'd2, 16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh8000);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random();
  endtask

  task automatic test_backpressure();
    in_ch.valid = 1'b0;
    @(negedge clk);
    hold_cycles = 300;
    repeat (120) send_random();
  endtask

  task automatic test_streaming(input int count);
    idle_on = 1'b0;
    repeat (count) send_random();
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    idle_on = 1'b1;
    test_random(1100);
    test_backpressure();
    test_streaming(300);
    in_ch.valid = 1'b0;
    while (unit_queue.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
